>>> rtl/quad_strip_plane_normal_defines.svh
// assertion macros for the quad strip plane normal block
`ifndef QUAD_STRIP_PLANE_NORMAL_DEFINES_SVH
`define QUAD_STRIP_PLANE_NORMAL_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define QSPN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define QSPN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/qspn_pkg.sv
// shared types and constants for the quad strip plane normal block
`timescale 1ns / 1ps
package qspn_pkg;
    localparam int unsigned EPS_W = 31;
    localparam int unsigned PT_W  = 32;
    localparam int unsigned NRM_W = 32;
    localparam int unsigned OFS_W = 48;

    // coordinates are signed values of this many bits, sign-extended to PT_W
    localparam int unsigned COORD_WIDTH = 32;

    typedef struct packed {
        logic                    start_surface;
        logic signed [PT_W-1:0]  point_a_x;
        logic signed [PT_W-1:0]  point_a_y;
        logic signed [PT_W-1:0]  point_a_z;
        logic signed [PT_W-1:0]  point_b_x;
        logic signed [PT_W-1:0]  point_b_y;
        logic signed [PT_W-1:0]  point_b_z;
    } t_req;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic signed [OFS_W-1:0] plane_offset;
        logic                    degenerate;
        logic                    face_up;
        logic                    surface_up_so_far;
    } t_rsp;
endpackage

>>> rtl/quad_strip_plane_normal.sv
// top level of the quad strip plane normal block
`timescale 1ns / 1ps
`include "quad_strip_plane_normal_defines.svh"
// Per-face plane of a strip of rulings. Each request carries a ruling (points a and b, Q16.16)
// and a start-of-surface mark; a start request (or the first request after reset) is stored
// and gives no result. Every later request closes a quad with the stored ruling and gives one
// result: the unit normal of (a - prev a) x (b - prev a) in Q1.NORMAL_FRAC_BITS, the plane
// offset -n.prev_a in Q31.16 (rounded half away from zero, saturated), a degenerate flag for
// a zero cross product, face_up (normal z above the epsilon register) and a running flag that
// every face of the surface so far is up. One request is worked at a time by a small sequencer
// around one shared 32x32 multiplier and one shared shift/subtract unit: cross product six
// products, a normalizing shift one bit a cycle, three squares, a 32-step root, three 63-step
// restoring divisions and three offset products. The time a face takes varies with the number
// of normalizing shifts and goes mostly to the root and divisions (one quotient bit per
// cycle); a degenerate face skips the squares, root, divisions and offset products, and a
// start request only stores its ruling. The result sits in an output register so the next
// request can enter while it waits; only the loading of the following result holds off until
// it is taken. The epsilon register is written through i_cfg_we / i_cfg_data and should only
// change when idle.
module quad_strip_plane_normal
    import qspn_pkg::*;
#(
    parameter int unsigned NORMAL_FRAC_BITS = 30
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [EPS_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_req             i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output t_rsp             o_rsp
);
    // widths: coordinate differences, cross terms
    localparam int unsigned DW = COORD_WIDTH + 1;
    localparam int unsigned CW = 2 * DW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_CROSS, S_MAG, S_NORM, S_SQ, S_ROOT, S_DIV, S_DOT, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic [EPS_W-1:0] r_eps;
    logic signed [COORD_WIDTH-1:0] r_pa [3];
    logic signed [COORD_WIDTH-1:0] r_ca [3];
    logic signed [COORD_WIDTH-1:0] r_cb [3];
    logic r_have, r_all_up, r_start;
    logic signed [DW-1:0] r_e1 [3];
    logic signed [DW-1:0] r_e2 [3];
    logic signed [CW-1:0] r_c [3];
    logic [CW-1:0] r_m [3];
    logic [2:0] r_neg;
    logic [2:0] r_k;
    logic [5:0] r_cnt;
    logic [65:0] r_rem;
    logic [63:0] r_s;
    logic [31:0] r_root;
    logic [63:0] r_num;
    logic [31:0] r_q;
    logic signed [NRM_W-1:0] r_n [3];
    logic signed [127:0] r_acc;
    logic r_valid;
    t_rsp r_rsp;

    // shared unsigned multiplier, operands chosen by the sequencer
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        mul_sn;

    function automatic logic [31:0] mag32(input logic signed [DW-1:0] v);
        logic [DW-1:0] t;
        t = v[DW-1] ? DW'(-v) : DW'(v);
        return t[31:0];
    endfunction

    logic [1:0] cross_i1, cross_i2;
    always_comb begin
        // cross term k (even: e1[i1]*e2[i2], odd: e1[i2]*e2[i1]), component r_k/2
        unique case (r_k[2:1])
            2'd0:    begin cross_i1 = 2'd1; cross_i2 = 2'd2; end
            2'd1:    begin cross_i1 = 2'd2; cross_i2 = 2'd0; end
            default: begin cross_i1 = 2'd0; cross_i2 = 2'd1; end
        endcase
        mul_a = '0; mul_b = '0; mul_sn = 1'b0;
        unique case (r_state)
            S_CROSS: begin
                if (!r_k[0]) begin
                    mul_a  = mag32(r_e1[cross_i1]);
                    mul_b  = mag32(r_e2[cross_i2]);
                    mul_sn = r_e1[cross_i1][DW-1] ^ r_e2[cross_i2][DW-1];
                end else begin
                    mul_a  = mag32(r_e1[cross_i2]);
                    mul_b  = mag32(r_e2[cross_i1]);
                    mul_sn = r_e1[cross_i2][DW-1] ^ r_e2[cross_i1][DW-1];
                end
            end
            S_SQ: begin
                mul_a = r_m[r_k[1:0]][31:0];
                mul_b = r_m[r_k[1:0]][31:0];
            end
            S_DOT: begin
                mul_a = r_n[r_k[1:0]][NRM_W-1] ? 32'(-r_n[r_k[1:0]]) : 32'(r_n[r_k[1:0]]);
                mul_b = r_pa[r_k[1:0]][COORD_WIDTH-1] ? 32'(-{r_pa[r_k[1:0]][COORD_WIDTH-1],
                        r_pa[r_k[1:0]]}) : 32'(r_pa[r_k[1:0]]);
                mul_sn = r_n[r_k[1:0]][NRM_W-1] ^ r_pa[r_k[1:0]][COORD_WIDTH-1];
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    // any magnitude still above 31 bits / none reaching bit 30
    logic any_hi, any_lo, all_zero;
    always_comb begin
        any_hi = 1'b0; any_lo = 1'b1; all_zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (r_m[i][CW-1:31] != '0) any_hi = 1'b1;
            if (r_m[i][30]) any_lo = 1'b0;
            if (r_m[i] != '0) all_zero = 1'b0;
        end
    end

    // shared shift/subtract step for root and division
    logic [65:0] rt_trial;
    logic [65:0] rt_rem;
    logic [64:0] dv_rem;
    logic [64:0] dv_trial;
    always_comb begin
        rt_rem   = {r_rem[63:0], r_s[63:62]};
        rt_trial = rt_rem - {32'd0, r_root, 2'b01};
        dv_rem   = {r_rem[63:0], r_num[63]};
        dv_trial = dv_rem - {33'd0, r_root};
    end

    localparam logic [31:0] LIM = 32'(64'd1 << NORMAL_FRAC_BITS);
    logic [31:0] q_round;
    logic signed [127:0] acc_neg, dm, dsh;
    logic signed [OFS_W-1:0] d_sat;
    always_comb begin
        q_round = (r_q > LIM) ? LIM : r_q;
        acc_neg = -r_acc;
        dm  = acc_neg[127] ? -acc_neg : acc_neg;
        dsh = (dm + (128'sd1 <<< (NORMAL_FRAC_BITS - 1))) >>> NORMAL_FRAC_BITS;
        if (acc_neg[127])
            d_sat = (dsh > (128'sd1 <<< 47)) ? {1'b1, {(OFS_W-1){1'b0}}} : OFS_W'(-dsh);
        else
            d_sat = (dsh > ((128'sd1 <<< 47) - 1)) ? {1'b0, {(OFS_W-1){1'b1}}} : OFS_W'(dsh);
    end

    logic signed [127:0] prod_s;
    assign prod_s = mul_sn ? -$signed({64'd0, mul_p}) : $signed({64'd0, mul_p});

    // finished face moves into the output register once the old result is gone
    logic rsp_load;
    assign rsp_load = (r_state == S_DOT) && (r_k == 3'd3) && (!r_valid || i_ready);

    assign o_ready = (r_state == S_IDLE) || (r_state == S_OUT);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_eps    <= '0;
            r_have   <= 1'b0;
            r_all_up <= 1'b1;
            r_valid  <= 1'b0;
            for (int i = 0; i < 3; i++) r_pa[i] <= '0;
        end else begin
            if (i_cfg_we) r_eps <= i_cfg_data;
            if (rsp_load) r_valid <= 1'b1;
            else if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE, S_OUT: begin
                    if (i_valid && o_ready) begin
                        r_ca[0] <= COORD_WIDTH'(i_req.point_a_x);
                        r_ca[1] <= COORD_WIDTH'(i_req.point_a_y);
                        r_ca[2] <= COORD_WIDTH'(i_req.point_a_z);
                        r_cb[0] <= COORD_WIDTH'(i_req.point_b_x);
                        r_cb[1] <= COORD_WIDTH'(i_req.point_b_y);
                        r_cb[2] <= COORD_WIDTH'(i_req.point_b_z);
                        r_start <= i_req.start_surface || !r_have;
                        r_state <= S_LOAD;
                    end else if (r_state == S_OUT && !r_valid) begin
                        r_state <= S_IDLE;
                    end
                end
                S_LOAD: begin
                    if (r_start) begin
                        // new surface: store ruling, no result
                        for (int i = 0; i < 3; i++) r_pa[i] <= r_ca[i];
                        r_have   <= 1'b1;
                        r_all_up <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            r_e1[i] <= DW'(r_ca[i]) - DW'(r_pa[i]);
                            r_e2[i] <= DW'(r_cb[i]) - DW'(r_pa[i]);
                            r_c[i]  <= '0;
                        end
                        r_k     <= '0;
                        r_state <= S_CROSS;
                    end
                end
                S_CROSS: begin
                    // even step adds, odd step subtracts
                    if (!r_k[0]) r_c[r_k[2:1]] <= r_c[r_k[2:1]] + CW'(prod_s);
                    else         r_c[r_k[2:1]] <= r_c[r_k[2:1]] - CW'(prod_s);
                    if (r_k == 3'd5) r_state <= S_MAG;
                    r_k <= r_k + 3'd1;
                end
                S_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= r_c[i][CW-1];
                        r_m[i]   <= r_c[i][CW-1] ? CW'(-r_c[i]) : CW'(r_c[i]);
                    end
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    // one bit of normalizing shift per cycle
                    if (all_zero) begin
                        r_state <= S_FIN;
                    end else if (any_hi) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (any_lo) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_s     <= '0;
                        r_k     <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_s <= r_s + mul_p;
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd2) begin
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    // two radicand bits per step, one root bit
                    r_s <= r_s << 2;
                    if (!rt_trial[65]) begin
                        r_rem  <= rt_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= rt_rem;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    if (r_cnt == 6'd31) begin
                        r_k     <= '0;
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 6'd0) begin
                        // load numerator (m << F) + len/2; its top bit is always clear
                        r_num <= ((64'(r_m[r_k[1:0]][31:0]) << NORMAL_FRAC_BITS)
                                  + 64'(r_root >> 1)) << 1;
                        r_rem <= '0;
                        r_q   <= '0;
                        r_cnt <= 6'd1;
                    end else begin
                        r_num <= r_num << 1;
                        if (!dv_trial[64]) begin
                            r_rem <= {1'b0, dv_trial};
                            r_q   <= {r_q[30:0], 1'b1};
                        end else begin
                            r_rem <= {1'b0, dv_rem};
                            r_q   <= {r_q[30:0], 1'b0};
                        end
                        if (r_cnt == 6'd63) begin
                            r_cnt <= '0;
                        end else begin
                            r_cnt <= r_cnt + 6'd1;
                        end
                        if (r_cnt == 6'd63) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (all_zero) begin
                        for (int i = 0; i < 3; i++) r_n[i] <= '0;
                        r_acc   <= '0;
                        r_k     <= 3'd3;
                        r_state <= S_DOT;
                    end else begin
                        r_n[r_k[1:0]] <= r_neg[r_k[1:0]] ? -$signed({1'b0, q_round[30:0]})
                                         : $signed({1'b0, q_round[30:0]});
                        if (r_k == 3'd2) begin
                            r_k     <= '0;
                            r_acc   <= '0;
                            r_state <= S_DOT;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DOT: begin
                    if (r_k == 3'd3) begin
                        // hold here while the previous result still waits
                        if (rsp_load) begin
                            r_rsp.normal_x     <= r_n[0];
                            r_rsp.normal_y     <= r_n[1];
                            r_rsp.normal_z     <= r_n[2];
                            r_rsp.plane_offset <= all_zero ? '0 : d_sat;
                            r_rsp.degenerate   <= all_zero;
                            r_rsp.face_up      <= !all_zero && (r_n[2] > $signed({1'b0, r_eps}));
                            r_rsp.surface_up_so_far <= r_all_up && !all_zero
                                                       && (r_n[2] > $signed({1'b0, r_eps}));
                            r_all_up <= r_all_up && !all_zero
                                        && (r_n[2] > $signed({1'b0, r_eps}));
                            for (int i = 0; i < 3; i++) r_pa[i] <= r_ca[i];
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_acc <= r_acc + prod_s;
                        r_k   <= r_k + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `QSPN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_valid && !i_ready, r_valid && $stable(o_rsp), "result dropped while waiting")
    `QSPN_ASSERT_NEXT(a_degen_zero, i_clk, i_rst_n, rsp_load && all_zero, o_rsp.plane_offset == '0 && !o_rsp.face_up, "degenerate face not zero")
    `QSPN_ASSERT_IMP(a_up_implies_face, i_clk, i_rst_n, r_valid && o_rsp.surface_up_so_far, o_rsp.face_up, "surface up without face up")
    `QSPN_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE || r_state == S_OUT, "ready while busy")
endmodule

>>> sim/quad_strip_plane_normal_checker.sv
// checker that predicts and compares face planes of the quad strip plane normal block
`timescale 1ns / 1ps
module quad_strip_plane_normal_checker
    import qspn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [EPS_W-1:0] i_cfg_data,
    input  logic             i_valid,
    input  logic             i_ready_in,
    input  t_req             i_req,
    input  logic             i_valid_out,
    input  logic             i_ready,
    input  t_rsp             i_rsp,
    output int               o_fail_count,
    output int               o_pending
);
    localparam int FRAC = 30;

    logic signed [63:0] prev_a [3];
    logic               have_prev;
    logic               surface_up;
    logic [EPS_W-1:0]   epsilon;
    t_rsp               planes_due [$];

    assign o_pending = planes_due.size();

    function automatic logic [127:0] mag128(logic signed [127:0] v);
        return v[127] ? -v : v;
    endfunction

    function automatic int bit_len(logic [127:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++) if (v[i]) n = i + 1;
        return n;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // stores the ruling on a start and returns 1 with the face plane otherwise
    function automatic bit face_plane(t_req q, output t_rsp p);
        logic signed [63:0]  a [3], b [3], e1 [3], e2 [3], nrm [3];
        logic signed [127:0] c [3], acc;
        logic [127:0]        mg [3], dm;
        logic [63:0]         m [3], s, len, qt;
        int                  maxb;
        bit                  degen, up;
        a[0] = q.point_a_x; a[1] = q.point_a_y; a[2] = q.point_a_z;
        b[0] = q.point_b_x; b[1] = q.point_b_y; b[2] = q.point_b_z;
        p = '0;
        if (q.start_surface || !have_prev) begin
            for (int i = 0; i < 3; i++) prev_a[i] = a[i];
            have_prev = 1;
            surface_up = 1;
            return 0;
        end
        for (int i = 0; i < 3; i++) begin
            e1[i] = a[i] - prev_a[i];
            e2[i] = b[i] - prev_a[i];
            nrm[i] = 0;
        end
        c[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e1[2]) * 128'(e2[1]);
        c[1] = 128'(e1[2]) * 128'(e2[0]) - 128'(e1[0]) * 128'(e2[2]);
        c[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e1[1]) * 128'(e2[0]);
        maxb = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = mag128(c[i]);
            if (bit_len(mg[i]) > maxb) maxb = bit_len(mg[i]);
        end
        degen = (maxb == 0);
        if (!degen) begin
            s = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = (maxb > 31) ? 64'(mg[i] >> (maxb - 31)) : 64'(mg[i] << (31 - maxb));
                s += m[i] * m[i];
            end
            len = root64(s);
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                qt = ((m[i] << FRAC) + (len >> 1)) / len;
                if (qt > (64'd1 << FRAC)) qt = 64'd1 << FRAC;
                nrm[i] = c[i][127] ? -$signed(qt) : $signed(qt);
                acc += 128'(nrm[i]) * 128'(prev_a[i]);
            end
            acc = -acc;
            dm = (mag128(acc) + (128'd1 << (FRAC - 1))) >> FRAC;
            if (acc[127]) begin
                if (dm > (128'd1 << 47)) dm = 128'd1 << 47;
                p.plane_offset = -dm[47:0];
            end else begin
                if (dm > (128'd1 << 47) - 1) dm = (128'd1 << 47) - 1;
                p.plane_offset = dm[47:0];
            end
        end
        up = !degen && (nrm[2] > $signed({33'd0, epsilon}));
        surface_up = surface_up && up;
        p.normal_x = nrm[0][31:0];
        p.normal_y = nrm[1][31:0];
        p.normal_z = nrm[2][31:0];
        p.degenerate = degen;
        p.face_up = up;
        p.surface_up_so_far = surface_up;
        for (int i = 0; i < 3; i++) prev_a[i] = a[i];
        return 1;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_rsp p, want;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) prev_a[i] = 0;
            have_prev = 0;
            surface_up = 1;
            epsilon = 0;
            o_fail_count = 0;
            planes_due.delete();
        end else begin
            if (i_cfg_we) epsilon = i_cfg_data;
            if (i_valid && i_ready_in && face_plane(i_req, p)) planes_due = {planes_due, p};
            if (i_valid_out && i_ready) begin
                if (planes_due.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = planes_due.pop_front();
                    if (i_rsp.normal_x !== want.normal_x)
                        report_mismatch("normal_x", i_rsp.normal_x, want.normal_x);
                    if (i_rsp.normal_y !== want.normal_y)
                        report_mismatch("normal_y", i_rsp.normal_y, want.normal_y);
                    if (i_rsp.normal_z !== want.normal_z)
                        report_mismatch("normal_z", i_rsp.normal_z, want.normal_z);
                    if (i_rsp.plane_offset !== want.plane_offset)
                        report_mismatch("plane_offset", i_rsp.plane_offset, want.plane_offset);
                    if (i_rsp.degenerate !== want.degenerate)
                        report_mismatch("degenerate", i_rsp.degenerate, want.degenerate);
                    if (i_rsp.face_up !== want.face_up)
                        report_mismatch("face_up", i_rsp.face_up, want.face_up);
                    if (i_rsp.surface_up_so_far !== want.surface_up_so_far)
                        report_mismatch("surface_up_so_far", i_rsp.surface_up_so_far,
                                        want.surface_up_so_far);
                end
            end
        end
    end
endmodule

>>> sim/quad_strip_plane_normal_tb.sv
// testbench top for the quad strip plane normal block
`timescale 1ns / 1ps
module quad_strip_plane_normal_tb;
    import qspn_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 400;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             cfg_we = 0;
    logic [EPS_W-1:0] cfg_data = '0;
    logic             req_valid = 0;
    logic             req_ready;
    t_req             req = '0;
    logic             rsp_valid;
    logic             rsp_ready = 0;
    t_rsp             rsp;
    int               fail_count;
    int               planes_pending;
    int               cycle_count = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;

    always #5 i_clk = ~i_clk;

    quad_strip_plane_normal dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_ready(req_ready), .i_req(req),
        .o_valid(rsp_valid), .i_ready(rsp_ready), .o_rsp(rsp)
    );

    quad_strip_plane_normal_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .i_ready_in(req_ready), .i_req(req),
        .i_valid_out(rsp_valid), .i_ready(rsp_ready), .i_rsp(rsp),
        .o_fail_count(fail_count), .o_pending(planes_pending)
    );

    // receiver stalls at random
    always @(posedge i_clk) begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // send one request, holding it until accepted; random gaps before
    task automatic send_request(t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 0;
            @(posedge i_clk);
        end
        req_valid <= 1;
        req <= r;
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
    endtask

    // wait until every face result is back, then let the block settle
    task automatic drain();
        req_valid <= 0;
        while (planes_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_epsilon(logic [EPS_W-1:0] v);
        cfg_we <= 1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            default: return 32'($signed($urandom_range(200000)) - 100000);
        endcase
    endfunction

    function automatic t_req rand_ruling(bit start);
        t_req r;
        r.start_surface = start;
        r.point_a_x = rand_coord(); r.point_a_y = rand_coord(); r.point_a_z = rand_coord();
        r.point_b_x = rand_coord(); r.point_b_y = rand_coord(); r.point_b_z = rand_coord();
        return r;
    endfunction

    function automatic t_req ruling(bit s, int ax, int ay, int az, int bx, int by, int bz);
        t_req r;
        r.start_surface = s;
        r.point_a_x = ax; r.point_a_y = ay; r.point_a_z = az;
        r.point_b_x = bx; r.point_b_y = by; r.point_b_z = bz;
        return r;
    endfunction

    // a strip of faces: mostly regular climbing rulings, some fully random
    task automatic random_strip();
        int faces, x0, y0;
        t_req r;
        faces = $urandom_range(1, 8);
        x0 = $urandom_range(65536 * 50);
        y0 = $urandom_range(65536 * 50);
        send_request(rand_ruling(1));
        for (int k = 0; k < faces; k++) begin
            if ($urandom_range(3) == 0) begin
                r = rand_ruling(0);
            end else begin
                r = ruling(0, x0 + (k + 1) * 65536 + $urandom_range(4000),
                           y0 + $urandom_range(4000), $urandom_range(65536),
                           x0 + (k + 1) * 65536, y0 + 65536 + $urandom_range(4000),
                           $urandom_range(65536));
            end
            send_request(r);
        end
    endtask

    initial begin
        logic [EPS_W-1:0] eps_set [4];
        eps_set[0] = 0; eps_set[1] = 31'h4000_0000; eps_set[2] = 31'h2d41_3ccd;
        eps_set[3] = 31'h7fff_ffff;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: ruling without start mark, extremes, flat and degenerate faces
        send_request(ruling(0, 0, 0, 0, 65536, 0, 0));
        send_request(ruling(0, 65536, 0, 0, 0, 65536, 0));
        send_request(ruling(0, 65536, 0, 0, 0, 65536, 0));   // zero-length normal
        send_request(ruling(1, 0, 0, 0, 0, 65536, 0));
        send_request(ruling(0, 65536, 0, 0, 65536, 65536, 0)); // upward face
        send_request(ruling(0, 131072, 0, 0, 131072, -65536, 0)); // downward face
        send_request(ruling(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_request(ruling(0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        send_request(ruling(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
        send_request(ruling(0, 5, 3, -7, 1, 1, 1)); // large cross, shifted down
        send_request(ruling(1, 32'h7fff_0000, 32'h7fff_0000, 32'h7fff_0000, 0, 0, 0));
        send_request(ruling(0, 32'h8000_0000, 32'h7fff_0000, 32'h7fff_0000,
                            32'h7fff_0000, 32'h8000_0000, 32'h7fff_0000)); // large negative offset
        drain();

        // random phases over several thresholds and idle patterns
        for (int ph = 0; ph < 12; ph++) begin
            write_epsilon((ph % 4 == 3) ? 31'($urandom()) : eps_set[ph % 4]);
            send_idle_pct = (ph < 4) ? 24 : (ph < 8) ? 68 : 0;
            recv_idle_pct = (ph < 4) ? 68 : (ph < 8) ? 24 : 0;
            for (int k = 0; k < 20; k++) begin
                random_strip();
                if (k == 12) begin
                    req_valid <= 0;
                    while (planes_pending != 0) @(posedge i_clk);
                end
            end
            if ($urandom_range(1)) send_request(rand_ruling($urandom_range(1)));
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
